// ===== rtl/core/ddf_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal digit formatter package
// Beat types and symbol codes shared by the formatter and its checker.
// ----------------------------------------------------------------------------
package ddf_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SymbolW = 4;
  localparam int unsigned BitCntW = 5;

  localparam logic [SymbolW-1:0] SymPoint = 4'd10;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] min_int_digits;
    logic [CountW-1:0] frac_digits;
  } ddf_in_t;

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last;
  } ddf_out_t;

  // Per-cycle controls for the BCD cell row.
  typedef struct packed {
    logic clear;   // zero every digit
    logic dabble;  // add-3 correct and shift one binary bit in
    logic shift;   // move digits up by one position
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ddf_cell.sv =====
// ----------------------------------------------------------------------------
// Decimal digit formatter BCD cell
// One decimal digit of the double-dabble row; also shifts digits upward.
// ----------------------------------------------------------------------------
module ddf_cell (
  input  logic              clk_i,
  input  ddf_pkg::cell_ctrl_t ctrl_i,
  input  logic              carry_i,
  input  logic [3:0]        digit_i,
  output logic              carry_o,
  output logic [3:0]        digit_o
);
  import ddf_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Correct digits of five or more so the doubling carries out decimally.
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

// ===== rtl/core/decimal_digit_formatter.sv =====
// ----------------------------------------------------------------------------
// Decimal digit formatter
// Binary to decimal symbols with leading-zero blanking and a decimal point.
// ----------------------------------------------------------------------------
// One beat in carries a 32-bit value, a minimum integer width and a fraction
// width; the block returns the shown digits most significant first, with a
// point symbol (code 10) ahead of the first fractional digit and last set on
// the final digit. A value of zero with both widths zero returns no beats.
// One item at a time: the input stalls while an item is in work. Each item
// first runs serial double dabble through the row of BCD cells, one value
// bit per cycle; then the row shifts up one digit position per cycle past
// the emit logic, except while an output stall or a point symbol holds it.
// ----------------------------------------------------------------------------
module decimal_digit_formatter #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ddf_pkg::ddf_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ddf_pkg::ddf_out_t out_data_o
);
  import ddf_pkg::*;

  localparam int unsigned PosW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned CmpW = (PosW + 1 > CountW + 1) ? PosW + 1 : CountW + 1;
  localparam logic [PosW-1:0] TopPos = PosW'(NUM_DIGITS - 1);

  // Sequencer codes.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               seen_q, seen_d;
  logic               point_done_q, point_done_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers: no reset needed.
  logic [ValueW-1:0]  val_q, val_d;
  logic [CountW-1:0]  min_int_q, min_int_d;
  logic [CountW-1:0]  frac_q, frac_d;
  ddf_out_t           out_q, out_d;

  cell_ctrl_t         cell_ctrl;
  logic [NUM_DIGITS:0]  carry;
  logic [3:0]         digit [NUM_DIGITS];

  logic               in_acc;
  logic               step_en;
  logic [3:0]         top_digit;
  logic [CmpW-1:0]    keep_ext, pos_ext, frac_ext;
  logic               show, at_point, emit_point, advance;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // Row of BCD cells; the value enters at cell 0 MSB first, and during
  // emission digits move towards the top cell, which feeds the emit logic.
  assign carry[0] = val_q[ValueW-1];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    logic [3:0] lower;
    if (g == 0) begin : g_bottom
      assign lower = 4'd0;
    end else begin : g_upper
      assign lower = digit[g-1];
    end
    ddf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[g]),
      .digit_i (lower),
      .carry_o (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  assign top_digit = digit[NUM_DIGITS-1];

  // Blank a position until a nonzero digit appears or it lies within the
  // kept width; the point goes just ahead of the digit at frac - 1.
  assign keep_ext = CmpW'(min_int_q) + CmpW'(frac_q);
  assign pos_ext  = CmpW'(pos_q);
  assign frac_ext = CmpW'(frac_q);

  assign step_en    = (state_q == StEmit) && (!out_valid_q || !out_stall_i);
  assign show       = seen_q || (top_digit != 4'd0) || (keep_ext > pos_ext);
  assign at_point   = (frac_q != '0) && (frac_ext == pos_ext + CmpW'(1));
  assign emit_point = show && at_point && !point_done_q;
  assign advance    = step_en && !emit_point;

  always_comb begin
    cell_ctrl.clear  = in_acc;
    cell_ctrl.dabble = (state_q == StConv);
    cell_ctrl.shift  = advance;
  end

  always_comb begin
    state_d      = state_q;
    bit_cnt_d    = bit_cnt_q;
    pos_d        = pos_q;
    seen_d       = seen_q;
    point_done_d = point_done_q;
    val_d        = val_q;
    min_int_d    = min_int_q;
    frac_d       = frac_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    // Drop the held beat once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          val_d     = in_data_i.value;
          min_int_d = in_data_i.min_int_digits;
          frac_d    = in_data_i.frac_digits;
          bit_cnt_d = BitCntW'(ValueW - 1);
          state_d   = StConv;
        end
      end
      StConv: begin
        val_d = {val_q[ValueW-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          pos_d        = TopPos;
          seen_d       = 1'b0;
          point_done_d = 1'b0;
          state_d      = StEmit;
        end else begin
          bit_cnt_d = bit_cnt_q - BitCntW'(1);
        end
      end
      StEmit: begin
        if (step_en && show) begin
          out_valid_d = 1'b1;
          if (emit_point) begin
            out_d.symbol = SymPoint;
            out_d.last   = 1'b0;
          end else begin
            out_d.symbol = top_digit;
            out_d.last   = (pos_q == '0);
          end
        end
        if (emit_point && step_en) begin
          point_done_d = 1'b1;
        end
        if (advance) begin
          if (top_digit != 4'd0) begin
            seen_d = 1'b1;
          end
          if (pos_q == '0) begin
            state_d = StIdle;
          end else begin
            pos_d = pos_q - PosW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      bit_cnt_q    <= '0;
      pos_q        <= '0;
      seen_q       <= 1'b0;
      point_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_cnt_q    <= bit_cnt_d;
      pos_q        <= pos_d;
      seen_q       <= seen_d;
      point_done_q <= point_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    min_int_q <= min_int_d;
    frac_q    <= frac_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/ddf_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal digit formatter checker
// Port-level assertions, bound to the formatter top level.
// ----------------------------------------------------------------------------
module ddf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ddf_pkg::ddf_out_t out_data_o
);
  import ddf_pkg::*;

  // Stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // An accepted item keeps the input busy while it converts.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Only digit and point codes appear.
  a_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.symbol <= SymPoint)
    else $error("symbol code out of range");

  // A point is never marked last; a digit always follows it.
  a_point_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.symbol == SymPoint |-> !out_data_o.last)
    else $error("point symbol marked last");

endmodule

bind decimal_digit_formatter ddf_checker u_ddf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Decimal digit formatter testbench
// Drives numbers with assorted widths and checks the stream of shown symbols.
// ----------------------------------------------------------------------------
// A short directed table comes first. Its rows where the answer is plain
// (nothing shown, largest value, all zeros, no point, wide fraction) carry their
// symbols typed in. The rest of the table, and several hundred random beats
// after it, are checked against a digit-splitting predictor kept here. Every
// result beat is matched, in order, with the oldest expected symbol. Four
// handshake phases follow one another: free flow, an idle sender, a stalling
// receiver, and both together. At each phase boundary the sender holds off
// until every expected symbol has come out.
// ----------------------------------------------------------------------------
module tb_top;
  import ddf_pkg::*;

  localparam int NumDigits   = 10;
  localparam int RandomBeats = 448;  // spread over four handshake phases
  localparam int DrainCycles = 60;   // a little over one item's latency
  localparam int StuckLimit  = 2000; // cycles with no beat on either side

  // One row of the directed table. With typed set, n and syms hold the
  // expected symbols, the first symbol in the leftmost nibble.
  typedef struct packed {
    logic [ValueW-1:0]      value;
    logic [CountW-1:0]      min_int;
    logic [CountW-1:0]      frac;
    logic                   typed;
    logic [3:0]             n;
    logic [0:10][SymbolW-1:0] syms;
  } directed_row_t;

  localparam int DirectedRows = 22;

  directed_row_t directed_rows [DirectedRows] = '{
    // nothing shown: zero with no minimum width
    '{32'd0,          4'd0,  4'd0,  1'b1, 4'd0,  44'h0},
    '{32'd0,          4'd1,  4'd0,  1'b1, 4'd1,  44'h0_0000000000},
    '{32'hFFFF_FFFF,  4'd0,  4'd0,  1'b1, 4'd10, 44'h4294967295_0},
    // a fraction wider than the digit row shows no point
    '{32'hFFFF_FFFF,  4'd0,  4'd15, 1'b1, 4'd10, 44'h4294967295_0},
    '{32'd0,          4'd0,  4'd2,  1'b1, 4'd3,  44'hA00_00000000},
    '{32'd0,          4'd10, 4'd10, 1'b1, 4'd11, 44'hA0000000000},
    '{32'd0,          4'd15, 4'd15, 1'b1, 4'd10, 44'h0000000000_0},
    '{32'd1,          4'd0,  4'd0,  1'b1, 4'd1,  44'h1_0000000000},
    '{32'd1,          4'd0,  4'd1,  1'b1, 4'd2,  44'hA1_000000000},
    // from here on the predictor works out the symbols
    '{32'd12345,      4'd3,  4'd2,  1'b0, 4'd0,  44'h0},
    '{32'd1000000000, 4'd0,  4'd10, 1'b0, 4'd0,  44'h0},
    '{32'd999999999,  4'd0,  4'd10, 1'b0, 4'd0,  44'h0},
    '{32'd7,          4'd0,  4'd3,  1'b0, 4'd0,  44'h0},
    '{32'd7,          4'd2,  4'd3,  1'b0, 4'd0,  44'h0},
    '{32'd100,        4'd0,  4'd0,  1'b0, 4'd0,  44'h0},
    '{32'h8000_0000,  4'd4,  4'd4,  1'b0, 4'd0,  44'h0},
    '{32'd42,         4'd0,  4'd11, 1'b0, 4'd0,  44'h0},
    '{32'd5,          4'd10, 4'd0,  1'b0, 4'd0,  44'h0},
    '{32'd0,          4'd0,  4'd1,  1'b0, 4'd0,  44'h0},
    '{32'd3000000000, 4'd9,  4'd1,  1'b0, 4'd0,  44'h0},
    '{32'h5555_5555,  4'd5,  4'd5,  1'b0, 4'd0,  44'h0},
    '{32'hAAAA_AAAA,  4'd10, 4'd6,  1'b0, 4'd0,  44'h0}
  };

  // Idle and stall odds, in percent, for each handshake phase.
  int send_idle_pct  [4] = '{0, 65, 0, 32};
  int recv_stall_pct [4] = '{0, 0, 65, 32};

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  ddf_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ddf_out_t out_data;

  ddf_out_t expected_symbols [$];

  int idle_pct;
  int stall_pct;
  int mismatches;
  int numbers_sent;
  int blank_numbers;
  int symbols_checked;
  int points_checked;
  int stuck_cycles;

  decimal_digit_formatter #(
    .NUM_DIGITS (NumDigits)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Split the number into decimal digits and queue the symbols that should
  // come out: blank leading zeros outside the kept width, put a point ahead
  // of the first fractional digit, and mark the final symbol.
  function automatic void format_value(input ddf_in_t beat);
    logic [3:0]    digit [NumDigits];
    logic [31:0]   rest;
    int unsigned   keep;
    int unsigned   frac;
    int unsigned   queued;
    bit            seen_nonzero;
    ddf_out_t      sym;
    rest         = beat.value;
    frac         = int'(beat.frac_digits);
    keep         = int'(beat.min_int_digits) + frac;
    queued       = expected_symbols.size();
    seen_nonzero = 1'b0;
    for (int pos = 0; pos < NumDigits; pos++) begin
      digit[pos] = 4'(rest % 10);
      rest       = rest / 10;
    end
    for (int pos = NumDigits - 1; pos >= 0; pos--) begin
      if (digit[pos] != 4'd0) seen_nonzero = 1'b1;
      if (seen_nonzero || keep > pos) begin
        if (frac != 0 && pos == frac - 1) begin
          sym.symbol = SymPoint;
          sym.last   = 1'b0;
          expected_symbols.push_back(sym);
        end
        sym.symbol = digit[pos];
        sym.last   = 1'b0;
        expected_symbols.push_back(sym);
      end
    end
    if (expected_symbols.size() > queued) begin
      sym      = expected_symbols.pop_back();
      sym.last = 1'b1;
      expected_symbols.push_back(sym);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [SymbolW-1:0] got,
                                 input logic [SymbolW-1:0] want);
    if (mismatches < 100)
      $display("MISMATCH %s: got %0d, expected %0d (symbol %0d)", what, got, want,
               symbols_checked);
    mismatches++;
  endtask

  task automatic check_symbol(input ddf_out_t got);
    ddf_out_t want;
    if (expected_symbols.size() == 0) begin
      report_mismatch("unexpected beat", got.symbol, '0);
    end else begin
      want = expected_symbols.pop_front();
      if (got.symbol !== want.symbol) report_mismatch("symbol", got.symbol, want.symbol);
      if (got.last !== want.last)
        report_mismatch("last", SymbolW'(got.last), SymbolW'(want.last));
      if (want.symbol == SymPoint) points_checked++;
    end
    symbols_checked++;
  endtask

  // Offer one beat, idling first at the phase's odds, and hold it until the
  // block takes it. Queue its symbols at the edge that accepts it.
  task automatic send_beat(input ddf_in_t beat, input logic typed, input logic [3:0] n,
                           input logic [0:10][SymbolW-1:0] syms);
    ddf_out_t sym;
    int       queued;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall);
    queued = expected_symbols.size();
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        sym.symbol = syms[i];
        sym.last   = (i == n - 1);
        expected_symbols.push_back(sym);
      end
    end else begin
      format_value(beat);
    end
    if (expected_symbols.size() == queued) blank_numbers++;
    numbers_sent++;
  endtask

  // Favour values with few digits and values near powers of ten, where the
  // blanking and the point placement are most interesting.
  function automatic ddf_in_t random_beat();
    ddf_in_t     beat;
    logic [31:0] span;
    span = 32'd1;
    repeat ($urandom_range(9)) span = span * 10;
    case ($urandom_range(5))
      0: beat.value = $urandom;
      1: beat.value = $urandom_range(999);
      2: beat.value = '0;
      3: beat.value = $urandom % span;
      4: beat.value = span + $urandom_range(4) - 2;
      default: beat.value = 32'hFFFF_FFFF - $urandom_range(20);
    endcase
    beat.min_int_digits = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(10));
    beat.frac_digits    = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(10));
    return beat;
  endfunction

  // Take result beats and choose the next stall at each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) check_symbol(out_data);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // End the run if neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("Timeout: no beat moved for %0d cycles", StuckLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    ddf_in_t beat;
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    mismatches      = 0;
    numbers_sent    = 0;
    blank_numbers   = 0;
    symbols_checked = 0;
    points_checked  = 0;
    stuck_cycles    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with free flow on both sides.
    foreach (directed_rows[r]) begin
      beat.value          = directed_rows[r].value;
      beat.min_int_digits = directed_rows[r].min_int;
      beat.frac_digits    = directed_rows[r].frac;
      send_beat(beat, directed_rows[r].typed, directed_rows[r].n, directed_rows[r].syms);
    end

    for (int ph = 0; ph < 4; ph++) begin
      // Drop valid and hold off until the block has returned everything.
      in_valid <= 1'b0;
      @(posedge clk_i);
      while (expected_symbols.size() != 0) @(posedge clk_i);
      idle_pct  = send_idle_pct[ph];
      stall_pct = recv_stall_pct[ph];
      for (int i = 0; i < RandomBeats / 4; i++)
        send_beat(random_beat(), 1'b0, '0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_symbols.size() != 0) @(posedge clk_i);
    // Allow a zero-symbol item still in work to show any stray beat.
    repeat (DrainCycles) @(posedge clk_i);

    $display("Formatted %0d numbers (%0d fully blank) over four handshake phases;",
             numbers_sent, blank_numbers);
    $display("checked %0d symbol beats, %0d of them decimal points.",
             symbols_checked, points_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
